### hdl/bal_pkg.sv
// shared types and codes for the bounded array list engine
package bal_pkg;

   localparam int DATA_W = 32;

   // command codes carried in the request beat
   typedef enum logic [3:0] {
      CMD_INSERT_AT    = 4'd0,
      CMD_INSERT_FRONT = 4'd1,
      CMD_INSERT_BACK  = 4'd2,
      CMD_DELETE_AT    = 4'd3,
      CMD_DELETE_FRONT = 4'd4,
      CMD_DELETE_BACK  = 4'd5,
      CMD_SEARCH       = 4'd6,
      CMD_ROTATE       = 4'd7,
      CMD_DUMP         = 4'd8
   } cmd_type;

   // the operation applied to every storage cell
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_INSERT,
      OP_DELETE,
      OP_ROT_USED,
      OP_ROT_RING
   } cell_op_type;

   typedef struct packed {
      logic [3:0]               command;
      logic signed [DATA_W-1:0] value;
      logic [3:0]               position;
      logic [7:0]               shift_amount;
   } req_type;

   typedef struct packed {
      logic                     ok;
      logic                     found;
      logic [2:0]               found_index;
      logic signed [DATA_W-1:0] slot_value;
      logic                     slot_used;
      logic [3:0]               element_count;
      logic                     last;
   } rsp_type;

endpackage

### hdl/bal_cell.sv
// one storage cell of the list row, fed by its neighbours
module bal_cell #(
   parameter int DEPTH = 8,
   parameter int IDX   = 0,
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  logic                             clock,
   input  bal_pkg::cell_op_type             op,
   input  logic [CW-1:0]                    pos,
   input  logic [CW-1:0]                    cnt,
   input  logic signed [bal_pkg::DATA_W-1:0] value,
   input  logic signed [bal_pkg::DATA_W-1:0] left_data,
   input  logic signed [bal_pkg::DATA_W-1:0] right_data,
   input  logic signed [bal_pkg::DATA_W-1:0] wrap_data,
   output logic signed [bal_pkg::DATA_W-1:0] data_q
);

   localparam logic [CW-1:0] IDX_C  = CW'(IDX);
   localparam logic [CW-1:0] IDX_NX = CW'(IDX + 1);

   logic signed [bal_pkg::DATA_W-1:0] entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (op)
         bal_pkg::OP_INSERT: begin
            if (IDX_C == pos) entry_in = value;
            else if (IDX_C > pos) entry_in = left_data;
         end
         bal_pkg::OP_DELETE: begin
            if (IDX_C >= pos) entry_in = right_data;
         end
         // left turn of the used part, head wraps to the tail
         bal_pkg::OP_ROT_USED: begin
            if (IDX_NX < cnt) entry_in = right_data;
            else if (IDX_NX == cnt) entry_in = wrap_data;
         end
         bal_pkg::OP_ROT_RING: entry_in = right_data;
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data_q = entry_ff;

endmodule

### hdl/bounded_array_list_engine.sv
// top level of the bounded array list engine
//
// keeps an ordered list of up to DEPTH signed 32-bit words in a row of DEPTH
// storage cells, each cell loading from its left or right neighbour, from the
// request word or from the head cell. insert and delete shift the row as the
// request is taken, answer with a registered result beat and leave the engine
// idle. search turns the whole row through the head cell once, one slot a
// cycle, and then answers when the result register can take the beat; dump
// does the same turn with one result beat per slot, waiting whenever a result
// beat is not taken; both leave the row as it was. rotate first reduces the
// distance modulo the element count (one distance bit per cycle) and then
// turns the used part left one slot a cycle, count minus the reduced distance
// times (none when that is zero). a request is taken only while the engine is
// idle and the result register is free or being emptied in that cycle, so a
// result beat waiting on rsp_stall holds off the next request. element_count
// and found_index are the low bits of the internal count and index.
module bounded_array_list_engine #(
   parameter int DEPTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bal_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bal_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);   // count width
   localparam int IW = $clog2(DEPTH);       // slot index width
   localparam int KW = (CW > 4) ? CW : 4;   // width for position compares
   localparam logic [CW-1:0] FULL_C   = CW'(DEPTH);
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOD,
      S_ROT,
      S_SCAN,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [2:0]    bit_ff, bit_in;
   logic [7:0]    amt_ff, amt_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in;
   logic          hit_ff, hit_in;
   logic          ok_ff, ok_in;
   logic          dump_ff, dump_in;
   logic signed [bal_pkg::DATA_W-1:0] val_ff, val_in;
   logic             rsp_valid_ff, rsp_valid_in;
   bal_pkg::rsp_type rsp_ff, rsp_in;

   // cell row control
   bal_pkg::cell_op_type cell_op;
   logic [CW-1:0]        cell_pos;
   logic signed [bal_pkg::DATA_W-1:0] cell_q [DEPTH];
   logic signed [bal_pkg::DATA_W-1:0] head;

   logic             out_free;
   logic             req_fire;
   logic             emit;
   logic             slot_live;
   logic [KW-1:0]    cnt_k, pos_k, sel_k;
   logic [CW:0]      trial;
   logic [CW-1:0]    rem_new;
   bal_pkg::rsp_type res;

   assign head      = cell_q[0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign req_fire  = req_valid && !req_stall;
   assign cnt_k     = KW'(count_ff);
   assign pos_k     = KW'(req_data.position);
   assign slot_live = CW'(idx_ff) < count_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      amt_in       = amt_ff;
      idx_in       = idx_ff;
      hit_idx_in   = hit_idx_ff;
      hit_in       = hit_ff;
      ok_in        = ok_ff;
      dump_in      = dump_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      cell_op      = bal_pkg::OP_HOLD;
      cell_pos     = '0;
      emit         = 1'b0;
      sel_k        = '0;
      trial        = '0;
      rem_new      = '0;
      res          = '0;
      res.last     = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_data.command) inside
                  bal_pkg::CMD_INSERT_AT, bal_pkg::CMD_INSERT_FRONT,
                  bal_pkg::CMD_INSERT_BACK: begin
                     if (req_data.command == bal_pkg::CMD_INSERT_AT) sel_k = pos_k;
                     else if (req_data.command == bal_pkg::CMD_INSERT_FRONT) sel_k = '0;
                     else sel_k = cnt_k;
                     // refused when full or past the end
                     if ((count_ff != FULL_C) && (sel_k <= cnt_k)) begin
                        cell_op  = bal_pkg::OP_INSERT;
                        cell_pos = CW'(sel_k);
                        count_in = count_ff + CW'(1);
                        res.ok   = 1'b1;
                     end
                     emit = 1'b1;
                  end
                  bal_pkg::CMD_DELETE_AT, bal_pkg::CMD_DELETE_FRONT,
                  bal_pkg::CMD_DELETE_BACK: begin
                     if (req_data.command == bal_pkg::CMD_DELETE_AT) sel_k = pos_k;
                     else if (req_data.command == bal_pkg::CMD_DELETE_FRONT) sel_k = '0;
                     else sel_k = cnt_k - KW'(1);
                     // refused when empty or not below the count
                     if ((count_ff != '0) && (sel_k < cnt_k)) begin
                        cell_op  = bal_pkg::OP_DELETE;
                        cell_pos = CW'(sel_k);
                        count_in = count_ff - CW'(1);
                        res.ok   = 1'b1;
                     end
                     emit = 1'b1;
                  end
                  bal_pkg::CMD_SEARCH: begin
                     val_in     = req_data.value;
                     dump_in    = 1'b0;
                     hit_in     = 1'b0;
                     hit_idx_in = '0;
                     ok_in      = 1'b0;
                     idx_in     = '0;
                     state_in   = S_SCAN;
                  end
                  bal_pkg::CMD_ROTATE: begin
                     // an empty list turns as a no-op that succeeds
                     if (count_ff == '0) begin
                        res.ok = 1'b1;
                        emit   = 1'b1;
                     end else begin
                        amt_in   = req_data.shift_amount;
                        bit_in   = 3'd7;
                        rem_in   = '0;
                        hit_in   = 1'b0;
                        ok_in    = 1'b1;
                        state_in = S_MOD;
                     end
                  end
                  bal_pkg::CMD_DUMP: begin
                     dump_in  = 1'b1;
                     idx_in   = '0;
                     state_in = S_SCAN;
                  end
                  default: emit = 1'b1;
               endcase
               if (emit) begin
                  res.element_count = 4'(count_in);
                  rsp_in            = res;
                  rsp_valid_in      = 1'b1;
               end
            end
         end

         // restoring remainder, one distance bit per cycle
         S_MOD: begin
            trial = {rem_ff, amt_ff[bit_ff]};
            if (trial >= {1'b0, count_ff}) trial = trial - {1'b0, count_ff};
            rem_new = trial[CW-1:0];
            rem_in  = rem_new;
            bit_in  = bit_ff - 3'd1;
            if (bit_ff == 3'd0) begin
               // a right turn by k is a left turn by count - k
               rem_in   = (rem_new == '0) ? '0 : count_ff - rem_new;
               state_in = S_ROT;
            end
         end

         S_ROT: begin
            if (rem_ff != '0) begin
               cell_op = bal_pkg::OP_ROT_USED;
               rem_in  = rem_ff - CW'(1);
            end else begin
               state_in = S_DONE;
            end
         end

         // whole row turns left once per step, slot idx sits in the head cell
         S_SCAN: begin
            if (dump_ff) begin
               if (out_free) begin
                  cell_op           = bal_pkg::OP_ROT_RING;
                  res.slot_value    = slot_live ? head : '0;
                  res.slot_used     = slot_live;
                  res.last          = (idx_ff == LAST_IDX);
                  res.element_count = 4'(count_ff);
                  rsp_in            = res;
                  rsp_valid_in      = 1'b1;
                  idx_in            = idx_ff + IW'(1);
                  if (idx_ff == LAST_IDX) state_in = S_IDLE;
               end
            end else begin
               cell_op = bal_pkg::OP_ROT_RING;
               if (slot_live && !hit_ff && (head == val_ff)) begin
                  hit_in     = 1'b1;
                  hit_idx_in = idx_ff;
               end
               idx_in = idx_ff + IW'(1);
               if (idx_ff == LAST_IDX) state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (out_free) begin
               res.ok            = ok_ff;
               res.found         = hit_ff;
               res.found_index   = hit_ff ? 3'(hit_idx_ff) : 3'd0;
               res.element_count = 4'(count_ff);
               rsp_in            = res;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff     <= rem_in;
      bit_ff     <= bit_in;
      amt_ff     <= amt_in;
      idx_ff     <= idx_in;
      hit_idx_ff <= hit_idx_in;
      hit_ff     <= hit_in;
      ok_ff      <= ok_in;
      dump_ff    <= dump_in;
      val_ff     <= val_in;
      rsp_ff     <= rsp_in;
   end

   // the cell row; the head cell closes the ring at the tail and feeds its own left input
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [bal_pkg::DATA_W-1:0] left_d, right_d;
      if (g == 0) begin : g_first
         assign left_d = cell_q[0];
      end else begin : g_mid_l
         assign left_d = cell_q[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
         assign right_d = cell_q[0];
      end else begin : g_mid_r
         assign right_d = cell_q[g+1];
      end
      bal_cell #(
         .DEPTH (DEPTH),
         .IDX   (g)
      ) u_cell (
         .clock      (clock),
         .op         (cell_op),
         .pos        (cell_pos),
         .cnt        (count_ff),
         .value      (req_data.value),
         .left_data  (left_d),
         .right_data (right_d),
         .wrap_data  (head),
         .data_q     (cell_q[g])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // count stays within the row
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_C)
      else $error("element count beyond capacity");

   // count moves by at most one element per cycle
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |->
         ((count_ff == $past(count_ff) + CW'(1)) ||
          (count_ff == $past(count_ff) - CW'(1))))
      else $error("element count jumped");

   // no turning of the used part on an empty list
   a_rot_nonempty: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_MOD) || (state_ff == S_ROT)) |-> (count_ff != '0))
      else $error("rotation running on an empty list");

   // busy sequencer never takes a new request
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("request taken while busy");

   // count is untouched while the row is being turned
   a_scan_count: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SCAN) || (state_ff == S_ROT)) |=> $stable(count_ff))
      else $error("count changed during a scan or turn");

endmodule

### tb/sv/bal_checker.sv
// result checker for the bounded array list engine: list predictor and beat compare
`timescale 1ns / 1ps
module bal_checker #(
   parameter int DEPTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  bal_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  bal_pkg::rsp_type rsp_data,
   output int               mismatches,
   output int               awaited,
   output int               beats_checked
);

   // own copy of the list
   logic signed [bal_pkg::DATA_W-1:0] list_words [DEPTH];
   int                                list_len;
   bal_pkg::rsp_type                  due_rsp [$];

   function automatic bal_pkg::rsp_type single_beat(input logic ok);
      bal_pkg::rsp_type b;
      b               = '0;
      b.ok            = ok;
      b.element_count = list_len[3:0];
      b.last          = 1'b1;
      return b;
   endfunction

   function automatic logic list_insert(input int pos,
                                        input logic signed [bal_pkg::DATA_W-1:0] v);
      if (list_len >= DEPTH || pos > list_len) return 1'b0;
      for (int i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
      list_words[pos] = v;
      list_len++;
      return 1'b1;
   endfunction

   function automatic logic list_delete(input int pos);
      if (list_len == 0 || pos >= list_len) return 1'b0;
      for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
      list_len--;
      return 1'b1;
   endfunction

   task automatic predict_list_results(input bal_pkg::req_type r);
      logic signed [bal_pkg::DATA_W-1:0] turned [DEPTH];
      bal_pkg::rsp_type b;
      int      hit;
      int      k;
      logic    ok;
      ok  = 1'b0;
      hit = -1;
      case (r.command)
         bal_pkg::CMD_INSERT_AT:    ok = list_insert(r.position, r.value);
         bal_pkg::CMD_INSERT_FRONT: ok = list_insert(0, r.value);
         bal_pkg::CMD_INSERT_BACK:  ok = list_insert(list_len, r.value);
         bal_pkg::CMD_DELETE_AT:    ok = list_delete(r.position);
         bal_pkg::CMD_DELETE_FRONT: ok = list_delete(0);
         bal_pkg::CMD_DELETE_BACK:
            ok = (list_len > 0) ? list_delete(list_len - 1) : 1'b0;
         bal_pkg::CMD_SEARCH: begin
            for (int i = list_len - 1; i >= 0; i--) if (list_words[i] == r.value) hit = i;
            b = single_beat(1'b0);
            if (hit >= 0) begin
               b.found       = 1'b1;
               b.found_index = hit[2:0];
            end
            due_rsp.push_back(b);
            return;
         end
         bal_pkg::CMD_ROTATE: begin
            // empty list turns as a no-op and still succeeds
            if (list_len > 0) begin
               k = r.shift_amount % list_len;
               for (int i = 0; i < list_len; i++) turned[(i + k) % list_len] = list_words[i];
               for (int i = 0; i < list_len; i++) list_words[i] = turned[i];
            end
            ok = 1'b1;
         end
         bal_pkg::CMD_DUMP: begin
            for (int i = 0; i < DEPTH; i++) begin
               b               = '0;
               b.element_count = list_len[3:0];
               b.last          = (i == DEPTH - 1);
               if (i < list_len) begin
                  b.slot_value = list_words[i];
                  b.slot_used  = 1'b1;
               end
               due_rsp.push_back(b);
            end
            return;
         end
         default: ok = 1'b0;
      endcase
      due_rsp.push_back(single_beat(ok));
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      bal_pkg::rsp_type want;
      if (reset) begin
         due_rsp.delete();
         list_len      = 0;
         mismatches    = 0;
         beats_checked = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_rsp.size() == 0) begin
               mismatches++;
               $display("%0t: result beat with nothing expected, expected none, got %0h",
                        $time, rsp_data);
            end else begin
               want = due_rsp.pop_front();
               check_field("ok", want.ok, rsp_data.ok);
               check_field("found", want.found, rsp_data.found);
               check_field("found_index", want.found_index, rsp_data.found_index);
               check_field("slot_value", want.slot_value, rsp_data.slot_value);
               check_field("slot_used", want.slot_used, rsp_data.slot_used);
               check_field("element_count", want.element_count, rsp_data.element_count);
               check_field("last", want.last, rsp_data.last);
               beats_checked++;
            end
         end
         if (req_valid && !req_stall) predict_list_results(req_data);
      end
      awaited <= due_rsp.size();
   end

endmodule

### tb/sv/tb_top.sv
// testbench top for the bounded array list engine: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_top;

   localparam int DEPTH        = 8;
   localparam int RESET_CYCLES = 7;
   localparam int HOLD_CYCLES  = 160;   // long receiver hold-off
   localparam int TAIL_CYCLES  = 40;    // covers a dump or a full rotate
   localparam int CYCLE_LIMIT  = 300000;

   // codes past the last opcode, answered with a plain refusal
   localparam logic [3:0] CMD_UNUSED_FIRST = 4'd9;
   localparam logic [3:0] CMD_UNUSED_LAST  = 4'd15;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   bal_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   bal_pkg::rsp_type rsp_data;

   // idling knobs; stall_pct and long_hold only change at a clock edge
   int      idle_pct    = 0;
   int      stall_pct   = 0;
   logic    long_hold   = 1'b0;
   int      hold_count  = 0;
   int      cycle_count = 0;
   int      sent_count  = 0;
   bit      code_seen [16];

   int      mismatches;
   int      awaited;
   int      beats_checked;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bounded_array_list_engine #(
      .DEPTH(DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   bal_checker #(
      .DEPTH(DEPTH)
   ) checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .mismatches   (mismatches),
      .awaited      (awaited),
      .beats_checked(beats_checked)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", CYCLE_LIMIT);
         $display("bounded_array_list_engine test failed");
         $finish;
      end
   end

   // receiver: random stall, or one long hold once the hold phase starts,
   // so the result register fills and the engine pushes back on requests
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold && hold_count < HOLD_CYCLES) begin
         rsp_stall  <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic bal_pkg::req_type list_cmd(input logic [3:0] code,
                                        input logic signed [bal_pkg::DATA_W-1:0] v,
                                        input logic [3:0] pos, input logic [7:0] amt);
      bal_pkg::req_type r;
      r.command      = code;
      r.value        = v;
      r.position     = pos;
      r.shift_amount = amt;
      return r;
   endfunction

   // grow_pct steers the list towards full or towards empty; small values
   // repeat often so that searches hit, wide values cover every bit
   function automatic bal_pkg::req_type random_list_cmd(input int grow_pct);
      bal_pkg::req_type r;
      int      pick;
      int      lane;
      pick = $urandom_range(99);
      lane = $urandom_range(99);
      if (lane < 60) begin
         r.value = int'($urandom_range(7)) - 3;
      end else if (lane < 90) begin
         r.value = $urandom;
      end else begin
         case ($urandom_range(3))
            0:       r.value = 32'h7fff_ffff;
            1:       r.value = 32'h8000_0000;
            2:       r.value = '0;
            default: r.value = '1;
         endcase
      end
      // mostly in range, now and then past any legal index
      r.position     = ($urandom_range(99) < 90) ? 4'($urandom_range(DEPTH))
                                                 : 4'($urandom_range(15, 9));
      r.shift_amount = 8'($urandom_range(255));
      if (pick < 3) begin
         r.command = 4'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
      end else if (pick < 3 + grow_pct) begin
         case ($urandom_range(2))
            0:       r.command = bal_pkg::CMD_INSERT_AT;
            1:       r.command = bal_pkg::CMD_INSERT_FRONT;
            default: r.command = bal_pkg::CMD_INSERT_BACK;
         endcase
      end else begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            case ($urandom_range(2))
               0:       r.command = bal_pkg::CMD_DELETE_AT;
               1:       r.command = bal_pkg::CMD_DELETE_FRONT;
               default: r.command = bal_pkg::CMD_DELETE_BACK;
            endcase
         end else if (pick < 75) begin
            r.command = bal_pkg::CMD_SEARCH;
         end else if (pick < 90) begin
            r.command = bal_pkg::CMD_ROTATE;
         end else begin
            r.command = bal_pkg::CMD_DUMP;
         end
      end
      return r;
   endfunction

   // offer one request beat, idling first at random, and hold it until taken;
   // valid is written once per edge so it never dips between back-to-back beats
   task automatic offer_command(input bal_pkg::req_type cmd);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      do @(posedge clock); while (req_stall);
      code_seen[cmd.command] = 1'b1;
      sent_count++;
   endtask

   // sender pause: drop valid and let the last beat be counted, then wait until
   // every predicted result beat has been taken
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
   endtask

   task automatic run_random(input int n, input int sender_idle, input int receiver_stall);
      stall_pct <= receiver_stall;
      idle_pct  = sender_idle;
      // alternate growing and shrinking stretches so both full and empty recur
      for (int i = 0; i < n; i++) offer_command(random_list_cmd(((i / 12) % 2) ? 20 : 55));
      wait_results_drained();
   endtask

   initial begin : stimulus
      int codes;
      codes = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list corner cases
      offer_command(list_cmd(bal_pkg::CMD_DUMP, 0, 4'd0, 8'd0));
      offer_command(list_cmd(bal_pkg::CMD_DELETE_FRONT, 0, 4'd0, 8'd0));
      offer_command(list_cmd(bal_pkg::CMD_DELETE_BACK, 0, 4'd0, 8'd0));
      offer_command(list_cmd(bal_pkg::CMD_DELETE_AT, 0, 4'd0, 8'd0));
      offer_command(list_cmd(bal_pkg::CMD_ROTATE, 0, 4'd0, 8'd200));   // empty rotate still ok
      offer_command(list_cmd(bal_pkg::CMD_SEARCH, 0, 4'd0, 8'd0));
      // value extremes, insert at the count, insert past the count
      offer_command(list_cmd(bal_pkg::CMD_INSERT_BACK, 32'h7fff_ffff, 4'd0, 8'd0));
      offer_command(list_cmd(bal_pkg::CMD_INSERT_FRONT, 32'h8000_0000, 4'd0, 8'd0));
      offer_command(list_cmd(bal_pkg::CMD_INSERT_AT, 0, 4'd1, 8'd0));
      offer_command(list_cmd(bal_pkg::CMD_INSERT_AT, 5, 4'd4, 8'd0));
      offer_command(list_cmd(bal_pkg::CMD_INSERT_AT, -1, 4'd3, 8'd0));
      offer_command(list_cmd(bal_pkg::CMD_SEARCH, -1, 4'd0, 8'd0));
      offer_command(list_cmd(bal_pkg::CMD_SEARCH, 12345, 4'd0, 8'd0));
      offer_command(list_cmd(bal_pkg::CMD_ROTATE, 0, 4'd0, 8'd255));
      offer_command(list_cmd(bal_pkg::CMD_DUMP, 0, 4'd0, 8'd0));
      // fill up, refusals when full and out of range, then a delete at the last slot
      offer_command(list_cmd(bal_pkg::CMD_INSERT_BACK, 11, 4'd0, 8'd0));
      offer_command(list_cmd(bal_pkg::CMD_INSERT_BACK, 22, 4'd0, 8'd0));
      offer_command(list_cmd(bal_pkg::CMD_INSERT_BACK, 33, 4'd0, 8'd0));
      offer_command(list_cmd(bal_pkg::CMD_INSERT_BACK, 44, 4'd0, 8'd0));
      offer_command(list_cmd(bal_pkg::CMD_INSERT_FRONT, 1, 4'd0, 8'd0));
      offer_command(list_cmd(bal_pkg::CMD_INSERT_AT, 2, 4'd15, 8'd0));
      offer_command(list_cmd(bal_pkg::CMD_DELETE_AT, 0, 4'd8, 8'd0));
      offer_command(list_cmd(bal_pkg::CMD_DELETE_AT, 0, 4'd7, 8'd0));
      offer_command(list_cmd(CMD_UNUSED_FIRST, 32'hffff_ffff, 4'd15, 8'hff));
      offer_command(list_cmd(CMD_UNUSED_LAST, 0, 4'd0, 8'd0));
      offer_command(list_cmd(bal_pkg::CMD_DUMP, 0, 4'd0, 8'd0));
      wait_results_drained();

      // random phases: no idling, sender idle, receiver stalls, both
      run_random(60, 0, 0);
      run_random(50, 71, 0);
      run_random(50, 0, 71);
      run_random(50, 34, 34);

      // back-pressure: receiver holds off while the sender keeps offering
      stall_pct <= 0;
      idle_pct  = 0;
      long_hold <= 1'b1;
      for (int i = 0; i < 20; i++) offer_command(random_list_cmd(40));

      wait_results_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      foreach (code_seen[c]) if (code_seen[c]) codes++;
      $display("covered %0d request beats over %0d command codes (unused codes included),",
               sent_count, codes);
      $display("%0d result beats checked, across idle/stall mixes and a %0d-cycle hold-off",
               beats_checked, HOLD_CYCLES);
      if (mismatches == 0 && awaited == 0) begin
         $display("bounded_array_list_engine test passed");
      end else begin
         $display("bounded_array_list_engine test failed");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/bal_pkg.sv
hdl/bal_cell.sv
hdl/bounded_array_list_engine.sv
tb/sv/bal_checker.sv
tb/sv/tb_top.sv
